### hw/rtl/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg
// Shared types, codes and field layout of the read coverage counter core.
// ----------------------------------------------------------------------------
package rcc_pkg;

	localparam int CHROMS_DEF     = 4;
	localparam int POSITIONS_DEF  = 65536;
	localparam int COUNT_BITS_DEF = 16;

	localparam int OP_W    = 2;
	localparam int CHROM_W = 2;
	localparam int POS_W   = 17;
	localparam int TRIM_W  = 8;
	localparam int QPOS_W  = 16;
	localparam int COV_W   = 16;

	localparam int S_TDATA_W = 64;
	localparam int S_TUSER_W = OP_W;
	localparam int M_TDATA_W = COV_W;

	localparam int CHROM_LSB = 0;
	localparam int START_LSB = CHROM_LSB + CHROM_W;
	localparam int END_LSB   = START_LSB + POS_W;
	localparam int TRIM_LSB  = END_LSB + POS_W;
	localparam int QPOS_LSB  = TRIM_LSB + TRIM_W;

	localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	typedef struct packed {
		logic valid;
		logic query;
		logic zero;
	} rcc_req_t;

endpackage

### hw/rtl/read_coverage_counter_core.sv
// ----------------------------------------------------------------------------
// read_coverage_counter_core
// Per-chromosome, per-position saturating coverage counters kept in one RAM.
// ----------------------------------------------------------------------------
// An add item walks each position it covers in turn and then passes a drain state, one
// counter read-modify-write per cycle through the single RAM port pair.
// A query passes the query and drain states before the next item; its result is registered
// by the RAM read and then by the result register. A query waits while an earlier result is
// held. Dropped adds leave the sequencer idle. After reset and after a clear item all
// 2^(CHROM_AW+POS_AW) RAM entries (262144 by default) are swept, one entry per cycle, while no item is accepted.
// ----------------------------------------------------------------------------
module read_coverage_counter_core #(
	parameter int CHROMS     = rcc_pkg::CHROMS_DEF,
	parameter int POSITIONS  = rcc_pkg::POSITIONS_DEF,
	parameter int COUNT_BITS = rcc_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// chrom[1:0], start_pos[18:2], end_pos[35:19], trim[43:36], query_pos[59:44], zero fill
	input  logic [rcc_pkg::S_TDATA_W-1:0] s_tdata,
	// op[1:0]
	input  logic [rcc_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// coverage[15:0]
	output logic [rcc_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int CHROM_AW = (CHROMS > 1) ? $clog2(CHROMS) : 1;
	localparam int POS_AW   = $clog2(POSITIONS);
	localparam int AW       = CHROM_AW + POS_AW;

	rcc_pkg::rcc_req_t       req;
	logic [AW-1:0]           req_addr;
	logic                    clr_we;
	logic [AW-1:0]           clr_addr;
	logic                    upd_we;
	logic [AW-1:0]           upd_waddr;
	logic [COUNT_BITS-1:0]   upd_wdata;
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [COUNT_BITS-1:0]   ram_wdata;
	logic [COUNT_BITS-1:0]   ram_rdata;

	rcc_seq #(
		.CHROMS    (CHROMS),
		.POSITIONS (POSITIONS),
		.CHROM_AW  (CHROM_AW),
		.POS_AW    (POS_AW)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.out_busy (m_tvalid),
		.req      (req),
		.req_addr (req_addr),
		.clr_we   (clr_we),
		.clr_addr (clr_addr)
	);

	assign ram_we    = clr_we || upd_we;
	assign ram_waddr = clr_we ? clr_addr : upd_waddr;
	assign ram_wdata = clr_we ? '0 : upd_wdata;

	rcc_ram #(
		.WIDTH  (COUNT_BITS),
		.ADDR_W (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (req.valid && !req.zero),
		.raddr (req_addr),
		.rdata (ram_rdata)
	);

	rcc_upd #(
		.COUNT_BITS (COUNT_BITS),
		.ADDR_W     (AW)
	) u_upd (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.req_addr (req_addr),
		.rdata    (ram_rdata),
		.we       (upd_we),
		.waddr    (upd_waddr),
		.wdata    (upd_wdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

### hw/rtl/rcc_ram.sv
// ----------------------------------------------------------------------------
// rcc_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module rcc_ram #(
	parameter int WIDTH  = 16,
	parameter int ADDR_W = 18
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/rcc_seq.sv
// ----------------------------------------------------------------------------
// rcc_seq
// Item decode and address sequencer: interval walk, query read, clear sweep.
// ----------------------------------------------------------------------------
module rcc_seq #(
	parameter int CHROMS    = rcc_pkg::CHROMS_DEF,
	parameter int POSITIONS = rcc_pkg::POSITIONS_DEF,
	parameter int CHROM_AW  = (CHROMS > 1) ? $clog2(CHROMS) : 1,
	parameter int POS_AW    = $clog2(POSITIONS)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [rcc_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic [rcc_pkg::S_TUSER_W-1:0]  s_tuser,
	input  logic                           out_busy,
	output rcc_pkg::rcc_req_t              req,
	output logic [CHROM_AW+POS_AW-1:0]     req_addr,
	output logic                           clr_we,
	output logic [CHROM_AW+POS_AW-1:0]     clr_addr
);

	localparam int AW = CHROM_AW + POS_AW;
	localparam int SW = (POS_AW + 2 > rcc_pkg::POS_W + 2) ? POS_AW + 2 : rcc_pkg::POS_W + 2;
	localparam logic signed [SW-1:0] PMAX = SW'(POSITIONS - 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_QRY   = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	logic [2:0]                       state_q;
	logic [CHROM_AW-1:0]              chrom_q;
	logic [POS_AW-1:0]                cur_q;
	logic [POS_AW-1:0]                hi_q;
	logic                             qzero_q;
	logic [AW-1:0]                    sweep_q;

	logic [rcc_pkg::OP_W-1:0]         op;
	logic [rcc_pkg::CHROM_W-1:0]      chrom;
	logic signed [rcc_pkg::POS_W-1:0] start_s;
	logic signed [rcc_pkg::POS_W-1:0] end_s;
	logic signed [rcc_pkg::TRIM_W-1:0] trim_s;
	logic [rcc_pkg::QPOS_W-1:0]       qpos;
	logic signed [SW-1:0]             lo_w;
	logic signed [SW-1:0]             hi_w;
	logic signed [SW-1:0]             hi_c;
	logic                             chrom_ok;
	logic                             qpos_ok;
	logic                             add_go;
	logic                             accept;

	assign op      = s_tuser;
	assign chrom   = s_tdata[rcc_pkg::CHROM_LSB +: rcc_pkg::CHROM_W];
	assign start_s = s_tdata[rcc_pkg::START_LSB +: rcc_pkg::POS_W];
	assign end_s   = s_tdata[rcc_pkg::END_LSB +: rcc_pkg::POS_W];
	assign trim_s  = s_tdata[rcc_pkg::TRIM_LSB +: rcc_pkg::TRIM_W];
	assign qpos    = s_tdata[rcc_pkg::QPOS_LSB +: rcc_pkg::QPOS_W];

	assign lo_w     = SW'(start_s) + SW'(trim_s);
	assign hi_w     = SW'(end_s) - SW'(trim_s);
	assign hi_c     = (hi_w > PMAX) ? PMAX : hi_w;
	assign chrom_ok = 9'(chrom) < 9'(CHROMS);
	assign qpos_ok  = 32'(qpos) < 32'(POSITIONS);
	assign add_go   = chrom_ok && !lo_w[SW-1] && !hi_w[SW-1] && (lo_w <= hi_c);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			sweep_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == {AW{1'b1}}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (op)
							rcc_pkg::OP_ADD: begin
								if (add_go) begin
									state_q <= ST_WALK;
								end
							end
							rcc_pkg::OP_QUERY: state_q <= ST_QRY;
							rcc_pkg::OP_CLEAR: begin
								sweep_q <= '0;
								state_q <= ST_CLEAR;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_WALK: begin
					if (cur_q == hi_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_QRY: begin
					if (!out_busy) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			chrom_q <= CHROM_AW'(chrom);
			qzero_q <= !(chrom_ok && qpos_ok);
			if (op == rcc_pkg::OP_QUERY) begin
				cur_q <= POS_AW'(qpos);
			end else begin
				cur_q <= lo_w[POS_AW-1:0];
			end
			hi_q <= hi_c[POS_AW-1:0];
		end else if (state_q == ST_WALK) begin
			cur_q <= cur_q + POS_AW'(1);
		end
	end

	always_comb begin
		req       = '0;
		req.valid = (state_q == ST_WALK) || ((state_q == ST_QRY) && !out_busy);
		req.query = (state_q == ST_QRY);
		req.zero  = (state_q == ST_QRY) && qzero_q;
	end

	assign req_addr = {chrom_q, cur_q};
	assign clr_we   = (state_q == ST_CLEAR);
	assign clr_addr = sweep_q;

endmodule

### hw/rtl/rcc_upd.sv
// ----------------------------------------------------------------------------
// rcc_upd
// Read data stage: saturating counter write-back and the query result register.
// ----------------------------------------------------------------------------
module rcc_upd #(
	parameter int COUNT_BITS = rcc_pkg::COUNT_BITS_DEF,
	parameter int ADDR_W     = 18
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  rcc_pkg::rcc_req_t             req,
	input  logic [ADDR_W-1:0]             req_addr,
	input  logic [COUNT_BITS-1:0]         rdata,
	output logic                          we,
	output logic [ADDR_W-1:0]             waddr,
	output logic [COUNT_BITS-1:0]         wdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [rcc_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam int XW = (COUNT_BITS > rcc_pkg::COV_W) ? COUNT_BITS : rcc_pkg::COV_W;
	localparam logic [XW-1:0] COV_MAX = XW'({rcc_pkg::COV_W{1'b1}});

	rcc_pkg::rcc_req_t          req_s1;
	logic [ADDR_W-1:0]          addr_s1;
	logic                       out_valid_q;
	logic [rcc_pkg::COV_W-1:0]  out_data_q;
	logic [XW-1:0]              rd_ext;
	logic [rcc_pkg::COV_W-1:0]  cov_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_s1 <= '0;
		end else begin
			req_s1 <= req;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= req_addr;
	end

	assign we    = req_s1.valid && !req_s1.query;
	assign waddr = addr_s1;
	assign wdata = (rdata == {COUNT_BITS{1'b1}}) ? rdata : rdata + COUNT_BITS'(1);

	assign rd_ext  = XW'(rdata);
	assign cov_sat = (rd_ext > COV_MAX) ? {rcc_pkg::COV_W{1'b1}} : rd_ext[rcc_pkg::COV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (req_s1.valid && req_s1.query) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_s1.valid && req_s1.query) begin
			out_data_q <= req_s1.zero ? '0 : cov_sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

### test/tb_read_coverage_counter_core.sv
// ----------------------------------------------------------------------------
// tb_read_coverage_counter_core
// Self-checking testbench for the read coverage counter core.
// ----------------------------------------------------------------------------
// Add, query and clear items go in through the slave stream. A copy of the
// coverage store in the testbench is updated for every accepted item, and
// each query predicts one coverage result. Results from the master stream are
// checked in order against those predictions. The run covers a directed set
// of corner cases, a run of adds that stacks up the counter of one position,
// and random traffic aimed at small hot regions. Both stream sides idle at
// random, and the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb_read_coverage_counter_core;

	localparam logic [rcc_pkg::OP_W-1:0] OP_NONE = 2'd3;
	localparam int COUNT_MAX    = (1 << rcc_pkg::COUNT_BITS_DEF) - 1;
	localparam int COV_MAX      = (1 << rcc_pkg::COV_W) - 1;
	localparam int RANDOM_ITEMS = 1280;
	localparam int SAT_ADDS     = 100;
	localparam int SAT_CHROM    = 2;
	localparam int SAT_POS      = 1000;
	localparam int LONG_HOLD    = 3000;
	localparam int DRAIN_CYCLES = 400;
	localparam int LIMIT_CYCLES = 5000000;

	typedef struct packed {
		logic [rcc_pkg::OP_W-1:0]    op;
		logic [rcc_pkg::CHROM_W-1:0] chrom;
		logic [rcc_pkg::POS_W-1:0]   start_pos;
		logic [rcc_pkg::POS_W-1:0]   end_pos;
		logic [rcc_pkg::TRIM_W-1:0]  trim;
		logic [rcc_pkg::QPOS_W-1:0]  query_pos;
	} read_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [rcc_pkg::S_TDATA_W-1:0] s_tdata;
	logic [rcc_pkg::S_TUSER_W-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [rcc_pkg::M_TDATA_W-1:0] m_tdata;

	read_item_t pending_reads[$];
	read_item_t drv_item = '0;
	logic [rcc_pkg::COV_W-1:0] cov_expect[$];
	int cov_cnt[int];

	logic in_taken = 1'b0;
	bit steady = 1'b0;
	int n_pushed = 0;
	int n_taken = 0;
	int n_errors = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int rx_phase_left = 0;
	int rx_stall_pct = 0;
	int burst_left = 0;
	int gap_left = 0;
	int cycle_cnt = 0;

	read_coverage_counter_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// chrom, start_pos, end_pos, trim, query_pos from bit 0 up, then zero fill.
	assign s_tdata = {4'b0, drv_item.query_pos, drv_item.trim, drv_item.end_pos,
		drv_item.start_pos, drv_item.chrom};
	// op
	assign s_tuser = drv_item.op;

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		n_errors++;
		if (n_errors <= 40) begin
			$display("[%0t] ERROR: %s", $time, msg);
		end
	endtask

	function automatic void track_coverage(input read_item_t it);
		int lo;
		int hi;
		int key;
		int v;
		lo = $signed(it.start_pos) + $signed(it.trim);
		hi = $signed(it.end_pos) - $signed(it.trim);
		case (it.op)
			rcc_pkg::OP_ADD: begin
				if (it.chrom < rcc_pkg::CHROMS_DEF && lo >= 0 && hi >= 0) begin
					if (hi > rcc_pkg::POSITIONS_DEF - 1) begin
						hi = rcc_pkg::POSITIONS_DEF - 1;
					end
					for (int p = lo; p <= hi; p++) begin
						key = it.chrom * rcc_pkg::POSITIONS_DEF + p;
						v = cov_cnt.exists(key) ? cov_cnt[key] : 0;
						cov_cnt[key] = (v < COUNT_MAX) ? v + 1 : v;
					end
				end
			end
			rcc_pkg::OP_QUERY: begin
				v = 0;
				key = it.chrom * rcc_pkg::POSITIONS_DEF + it.query_pos;
				if (it.chrom < rcc_pkg::CHROMS_DEF && it.query_pos < rcc_pkg::POSITIONS_DEF &&
					cov_cnt.exists(key)) begin
					v = cov_cnt[key];
				end
				if (v > COV_MAX) begin
					v = COV_MAX;
				end
				cov_expect.push_back(v[rcc_pkg::COV_W-1:0]);
			end
			rcc_pkg::OP_CLEAR: begin
				cov_cnt.delete();
			end
			default: begin
			end
		endcase
	endfunction

	function automatic read_item_t read_item(input logic [rcc_pkg::OP_W-1:0] op,
		input int chrom, input int start_pos, input int end_pos, input int trim,
		input int qpos);
		read_item_t it;
		it.op        = op;
		it.chrom     = chrom[rcc_pkg::CHROM_W-1:0];
		it.start_pos = start_pos[rcc_pkg::POS_W-1:0];
		it.end_pos   = end_pos[rcc_pkg::POS_W-1:0];
		it.trim      = trim[rcc_pkg::TRIM_W-1:0];
		it.query_pos = qpos[rcc_pkg::QPOS_W-1:0];
		return it;
	endfunction

	task automatic send(input read_item_t it);
		pending_reads.push_back(it);
		n_pushed++;
	endtask

	task automatic wait_drained();
		while (n_taken != n_pushed || cov_expect.size() != 0) begin
			@(negedge clk);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		logic [rcc_pkg::COV_W-1:0] exp_cov;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (cov_expect.size() == 0) begin
					report_mismatch($sformatf("coverage %0d arrived with nothing expected",
						m_tdata));
				end else begin
					exp_cov = cov_expect.pop_front();
					if (m_tdata !== exp_cov) begin
						report_mismatch($sformatf("coverage got %0d, expected %0d", m_tdata,
							exp_cov));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				track_coverage(drv_item);
				n_taken++;
			end
			in_taken <= s_tvalid && s_tready;
		end
	end

	always @(negedge clk) begin : driver
		logic vld;
		vld = s_tvalid && !in_taken;
		if (!arst_n) begin
			vld = 1'b0;
		end else if (!vld) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_reads.size() > 0) begin
				drv_item <= pending_reads.pop_front();
				vld = 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 40);
					if (steady) begin
						gap_left = 0;
					end else if ($urandom_range(0, 3) == 0) begin
						gap_left = $urandom_range(5, 40);
					end else begin
						gap_left = $urandom_range(0, 4);
					end
				end
			end
		end
		s_tvalid <= vld;
	end

	always @(negedge clk) begin : receiver
		logic rdy;
		if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = LONG_HOLD;
		end
		if (rx_phase_left == 0) begin
			rx_phase_left = $urandom_range(16, 256);
			case ($urandom_range(0, 3))
				0: rx_stall_pct = 0;
				1: rx_stall_pct = 25;
				2: rx_stall_pct = 60;
				default: rx_stall_pct = 90;
			endcase
		end else begin
			rx_phase_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			rdy = 1'b0;
		end else begin
			rdy = ($urandom_range(0, 99) >= rx_stall_pct);
		end
		m_tready <= rdy;
	end

	always @(posedge clk) begin : watchdog
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int hot_chrom;
		int hot_base;
		int chrom;
		int roll;
		int sp;
		int ep;
		int tr;
		int qp;
		int t;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send(read_item(rcc_pkg::OP_QUERY, 0, 0, 0, 0, 0));
		send(read_item(rcc_pkg::OP_ADD, 0, 0, 9, 0, 0));
		send(read_item(rcc_pkg::OP_QUERY, 0, 0, 0, 0, 0));
		send(read_item(rcc_pkg::OP_QUERY, 0, 0, 0, 0, 9));
		send(read_item(rcc_pkg::OP_QUERY, 0, 0, 0, 0, 10));
		// Negative trim pushes the end past the last position of the window.
		send(read_item(rcc_pkg::OP_ADD, 1, 65530, 65535, -10, 0));
		send(read_item(rcc_pkg::OP_QUERY, 1, 0, 0, 0, 65535));
		send(read_item(rcc_pkg::OP_QUERY, 1, 0, 0, 0, 65519));
		send(read_item(rcc_pkg::OP_ADD, 0, 5, 20, -6, 0));
		send(read_item(rcc_pkg::OP_ADD, 0, 100, 100, 127, 0));
		send(read_item(rcc_pkg::OP_QUERY, 0, 0, 0, 0, 5));
		send(read_item(rcc_pkg::OP_ADD, 3, 300, 305, 3, 0));
		send(read_item(rcc_pkg::OP_QUERY, 3, 0, 0, 0, 303));
		send(read_item(rcc_pkg::OP_ADD, 2, -1, -1, 0, 0));
		send(read_item(rcc_pkg::OP_ADD, 2, 200, 300, -128, 0));
		send(read_item(rcc_pkg::OP_QUERY, 2, 0, 0, 0, 72));
		send(read_item(rcc_pkg::OP_QUERY, 2, 0, 0, 0, 428));
		send(read_item(rcc_pkg::OP_ADD, 3, 65535, 65535, 0, 65535));
		send(read_item(rcc_pkg::OP_ADD, 3, -1, 10, 1, 0));
		send(read_item(rcc_pkg::OP_QUERY, 3, 0, 0, 0, 65535));
		send(read_item(OP_NONE, 3, -1, -1, -1, 65535));
		send(read_item(rcc_pkg::OP_QUERY, 3, 0, 0, 0, 0));
		send(read_item(rcc_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
		send(read_item(rcc_pkg::OP_QUERY, 1, 0, 0, 0, 65535));
		send(read_item(rcc_pkg::OP_QUERY, 2, 0, 0, 0, 72));
		wait_drained();

		// Back-to-back single-position adds stack up one counter.
		steady = 1'b1;
		for (int i = 0; i < SAT_ADDS; i++) begin
			t = $urandom_range(0, 3);
			send(read_item(rcc_pkg::OP_ADD, SAT_CHROM, SAT_POS - t, SAT_POS + t, t, $urandom));
			if (i % 16 == 0) begin
				send(read_item(rcc_pkg::OP_QUERY, SAT_CHROM, 0, 0, 0, SAT_POS));
			end
		end
		send(read_item(rcc_pkg::OP_QUERY, SAT_CHROM, 0, 0, 0, SAT_POS));
		send(read_item(rcc_pkg::OP_QUERY, SAT_CHROM, 0, 0, 0, SAT_POS - 1));
		send(read_item(rcc_pkg::OP_QUERY, SAT_CHROM, 0, 0, 0, SAT_POS + 1));
		wait_drained();
		steady = 1'b0;

		hold_req++;
		hot_chrom = 0;
		hot_base = 0;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 90 == 0) begin
				hot_chrom = $urandom_range(0, 3);
				if ($urandom_range(0, 3) == 0) begin
					hot_base = $urandom_range(65280, 65535);
				end else begin
					hot_base = $urandom_range(0, 65535);
				end
			end
			if (i == RANDOM_ITEMS / 2) begin
				wait_drained();
			end
			roll = $urandom_range(0, 99);
			chrom = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : hot_chrom;
			if (roll < 45) begin
				sp = hot_base + $urandom_range(0, 100);
				if (sp > 65535) begin
					sp = 65535 - $urandom_range(0, 20);
				end
				ep = sp + $urandom_range(0, 80);
				if (ep > 65535) begin
					ep = 65535;
				end
				tr = int'($urandom_range(0, 14)) - 4;
				send(read_item(rcc_pkg::OP_ADD, chrom, sp, ep, tr, $urandom));
			end else if (roll < 85) begin
				if ($urandom_range(0, 7) == 0) begin
					qp = $urandom_range(0, 65535);
				end else begin
					qp = hot_base + $urandom_range(0, 200);
					if (qp > 65535) begin
						qp = 65535;
					end
				end
				send(read_item(rcc_pkg::OP_QUERY, chrom, $urandom, $urandom, $urandom, qp));
			end else if (roll < 88) begin
				send(read_item(OP_NONE, $urandom, $urandom, $urandom, $urandom, $urandom));
			end else begin
				sp = $urandom_range(0, 131071);
				ep = sp + $urandom_range(0, 64);
				tr = int'($urandom_range(0, 255)) - 128;
				send(read_item(rcc_pkg::OP_ADD, $urandom_range(0, 3), sp, ep, tr, $urandom));
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (n_errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/rcc_pkg.sv
hw/rtl/rcc_ram.sv
hw/rtl/rcc_seq.sv
hw/rtl/rcc_upd.sv
hw/rtl/read_coverage_counter_core.sv
test/tb_read_coverage_counter_core.sv
